@@ hw/rtl/hfp_pkg.sv @@
// Shared types and constants for the HMM forward-probability block.
`timescale 1ns / 1ps

package hfp_pkg;

	localparam logic [1:0] KIND_PI    = 2'd0;
	localparam logic [1:0] KIND_TRANS = 2'd1;
	localparam logic [1:0] KIND_EMIT  = 2'd2;
	localparam logic [1:0] KIND_OBS   = 2'd3;

	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [10:0] EXP_MAX     = 11'h7FF;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ALIGN,
		F_NORM,
		F_UNDER,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_RD,
		S_OPA,
		S_WPROD,
		S_ADD,
		S_WACC,
		S_EMUL,
		S_WMUL,
		S_SWAP,
		S_SRD,
		S_SADD,
		S_WSUM,
		S_OUT
	} seq_state_t;

	typedef struct packed {
		logic        start;
		logic        op_add;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} fpu_rsp_t;

endpackage

@@ hw/rtl/hfp_fpu.sv @@
// Iterative IEEE double multiply and add unit with round to nearest even.
`timescale 1ns / 1ps

module hfp_fpu import hfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fpu_req_t req,
	output fpu_rsp_t rsp
);

	fpu_state_t         st_q, st_d;
	logic               sign_q, sign_d;
	logic               sub_q, sub_d;
	logic               zsign_q, zsign_d;
	logic signed [13:0] exp_q, exp_d;
	logic [52:0]        ma_q, ma_d, mb_q, mb_d;
	logic [105:0]       p_q, p_d, y_q, y_d;
	logic [10:0]        diff_q, diff_d;
	logic [1:0]         k_q, k_d;
	logic [63:0]        res_q, res_d;

	logic        sa, sb;
	logic [10:0] ea, eb, effa, effb;
	logic [51:0] fa, fb;
	logic [52:0] mant_a, mant_b;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_ge_b;
	logic        spec_hit;
	logic [63:0] spec_val;

	logic [26:0]  pa, pb;
	logic [53:0]  prod;
	logic [105:0] prod_sh;
	logic [105:0] sum;
	logic         rnd_up;
	logic [10:0]  field;
	logic [62:0]  mag;

	assign sa     = req.a[63];
	assign sb     = req.b[63];
	assign ea     = req.a[62:52];
	assign eb     = req.b[62:52];
	assign fa     = req.a[51:0];
	assign fb     = req.b[51:0];
	assign mant_a = {ea != 11'd0, fa};
	assign mant_b = {eb != 11'd0, fb};
	assign effa   = (ea == 11'd0) ? 11'd1 : ea;
	assign effb   = (eb == 11'd0) ? 11'd1 : eb;
	assign nan_a  = (ea == EXP_MAX) && (fa != 52'd0);
	assign nan_b  = (eb == EXP_MAX) && (fb != 52'd0);
	assign inf_a  = (ea == EXP_MAX) && (fa == 52'd0);
	assign inf_b  = (eb == EXP_MAX) && (fb == 52'd0);
	assign zero_a = (ea == 11'd0) && (fa == 52'd0);
	assign zero_b = (eb == 11'd0) && (fb == 52'd0);
	assign a_ge_b = req.a[62:0] >= req.b[62:0];

	always_comb begin
		spec_hit = 1'b1;
		spec_val = 64'd0;
		if (nan_a) begin
			spec_val = req.a | (64'd1 << 51);
		end else if (nan_b) begin
			spec_val = req.b | (64'd1 << 51);
		end else if (req.op_add) begin
			if (inf_a && inf_b && (sa != sb)) begin
				spec_val = DEFAULT_NAN;
			end else if (inf_a) begin
				spec_val = req.a;
			end else if (inf_b) begin
				spec_val = req.b;
			end else begin
				spec_hit = 1'b0;
			end
		end else begin
			if ((inf_a && zero_b) || (zero_a && inf_b)) begin
				spec_val = DEFAULT_NAN;
			end else if (inf_a || inf_b) begin
				spec_val = {sa ^ sb, EXP_MAX, 52'd0};
			end else if (zero_a || zero_b) begin
				spec_val = {sa ^ sb, 63'd0};
			end else begin
				spec_hit = 1'b0;
			end
		end
	end

	assign pa      = k_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
	assign pb      = k_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
	assign prod    = pa * pb;
	assign prod_sh = {52'd0, prod} << (7'(k_q[1]) * 7'd27 + 7'(k_q[0]) * 7'd27);
	assign sum     = sub_q ? (p_q - y_q) : (p_q + y_q);
	assign rnd_up  = p_q[52] & ((|p_q[51:0]) | p_q[53]);
	assign field   = p_q[105] ? exp_q[10:0] : 11'd0;
	assign mag     = {field, p_q[104:53]} + 63'(rnd_up);

	always_comb begin
		st_d    = st_q;
		sign_d  = sign_q;
		sub_d   = sub_q;
		zsign_d = zsign_q;
		exp_d   = exp_q;
		ma_d    = ma_q;
		mb_d    = mb_q;
		p_d     = p_q;
		y_d     = y_q;
		diff_d  = diff_q;
		k_d     = k_q;
		res_d   = res_q;
		case (st_q)
			F_IDLE: begin
				if (req.start) begin
					if (spec_hit) begin
						res_d = spec_val;
						st_d  = F_DONE;
					end else if (req.op_add) begin
						sub_d   = sa ^ sb;
						zsign_d = sa & sb;
						if (a_ge_b) begin
							sign_d = sa;
							p_d    = {1'b0, mant_a, 52'd0};
							y_d    = {1'b0, mant_b, 52'd0};
							diff_d = effa - effb;
							exp_d  = $signed(14'(effa)) + 14'sd1;
						end else begin
							sign_d = sb;
							p_d    = {1'b0, mant_b, 52'd0};
							y_d    = {1'b0, mant_a, 52'd0};
							diff_d = effb - effa;
							exp_d  = $signed(14'(effb)) + 14'sd1;
						end
						st_d = F_ALIGN;
					end else begin
						sign_d = sa ^ sb;
						ma_d   = mant_a;
						mb_d   = mant_b;
						p_d    = 106'd0;
						k_d    = 2'd0;
						exp_d  = $signed(14'(effa)) + $signed(14'(effb)) - 14'sd1022;
						st_d   = F_MUL;
					end
				end
			end
			F_MUL: begin
				p_d = p_q + prod_sh;
				k_d = k_q + 2'd1;
				if (k_q == 2'd3) begin
					st_d = F_NORM;
				end
			end
			F_ALIGN: begin
				if (diff_q == 11'd0) begin
					if (sum == 106'd0) begin
						res_d = {zsign_q, 63'd0};
						st_d  = F_DONE;
					end else begin
						p_d  = sum;
						st_d = F_NORM;
					end
				end else if (diff_q > 11'd60) begin
					y_d    = {105'd0, |y_q};
					diff_d = 11'd0;
				end else begin
					y_d    = {1'b0, y_q[105:2], y_q[1] | y_q[0]};
					diff_d = diff_q - 11'd1;
				end
			end
			F_NORM: begin
				if (!p_q[105] && (exp_q > 14'sd1)) begin
					p_d   = {p_q[104:0], 1'b0};
					exp_d = exp_q - 14'sd1;
				end else if (exp_q < 14'sd1) begin
					st_d = F_UNDER;
				end else begin
					st_d = F_ROUND;
				end
			end
			F_UNDER: begin
				if (exp_q < -14'sd110) begin
					p_d   = {105'd0, |p_q};
					exp_d = 14'sd1;
					st_d  = F_ROUND;
				end else if (exp_q < 14'sd1) begin
					p_d   = {1'b0, p_q[105:2], p_q[1] | p_q[0]};
					exp_d = exp_q + 14'sd1;
				end else begin
					st_d = F_ROUND;
				end
			end
			F_ROUND: begin
				if (exp_q >= 14'sd2047) begin
					res_d = {sign_q, EXP_MAX, 52'd0};
				end else begin
					res_d = {sign_q, mag};
				end
				st_d = F_DONE;
			end
			F_DONE: begin
				st_d = F_IDLE;
			end
			default: begin
				st_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		sign_q  <= sign_d;
		sub_q   <= sub_d;
		zsign_q <= zsign_d;
		exp_q   <= exp_d;
		ma_q    <= ma_d;
		mb_q    <= mb_d;
		p_q     <= p_d;
		y_q     <= y_d;
		diff_q  <= diff_d;
		k_q     <= k_d;
		res_q   <= res_d;
	end

	assign rsp.done   = (st_q == F_DONE);
	assign rsp.result = res_q;

endmodule

@@ hw/rtl/hmm_forward_probability.sv @@
// Top level: table memories, forward-vector banks and observation sequencer.
// An observation over n states sums fv*A over n states for each of n states and scales by B,
// or takes pi*B at the first of a sequence, then sums the n results, all on one shared
// double unit. A bad symbol goes straight to the result. item_ready is low meanwhile.
// Reset: num_states 16, num_symbols 64, forward vector reads as zero; tables hold no value.
`timescale 1ns / 1ps

module hmm_forward_probability import hfp_pkg::*; #(
	parameter int MAX_STATES  = 16,
	parameter int MAX_SYMBOLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  row_index,
	input  logic [5:0]  column_index,
	input  logic [63:0] table_value,
	input  logic [5:0]  obs_symbol,
	input  logic        first_of_sequence,
	input  logic        last_of_sequence,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [63:0] prefix_probability,
	output logic        end_of_sequence,
	output logic        symbol_error
);

	localparam int SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int AAW = (MAX_STATES > 1) ? $clog2(MAX_STATES * MAX_STATES) : 1;
	localparam int BAW = $clog2(MAX_STATES * MAX_SYMBOLS);
	localparam int FAW = $clog2(2 * MAX_STATES);
	localparam int FVD = 2 * MAX_STATES;

	logic [4:0] num_states_q;
	logic [6:0] num_symbols_q;

	logic [63:0] pi_mem [MAX_STATES];
	logic [63:0] a_mem  [MAX_STATES * MAX_STATES];
	logic [63:0] b_mem  [MAX_STATES * MAX_SYMBOLS];
	logic [63:0] fv_mem [FVD];
	logic [FVD-1:0] fv_vld_q;

	logic [63:0] pi_rd_q, a_rd_q, b_rd_q, fv_rd_q;
	logic        fv_vld_rd_q;
	logic [63:0] fv_rd;

	seq_state_t  st_q, st_d;
	logic [SW-1:0] i_q, i_d, j_q, j_d;
	logic [63:0] acc_q, acc_d;
	logic        bank_q, bank_d;
	logic [5:0]  sym_q;
	logic        first_q, last_q, err_q;
	logic        result_valid_q;
	logic [63:0] prob_q;
	logic        eos_q, serr_q;

	logic        accept, obs_accept, ld_pi, ld_a, ld_b;
	logic        sym_bad;
	logic [8:0]  sym_lim;
	logic [SW-1:0] n_last;
	logic        clr_vld, fv_we, rd_en, out_load;
	logic [FAW-1:0] fv_rd_addr, fv_wr_addr;
	logic [AAW-1:0] a_wr_addr, a_rd_addr;
	logic [BAW-1:0] b_wr_addr, b_rd_addr;
	fpu_req_t    fpu_req;
	fpu_rsp_t    fpu_rsp;

	hfp_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {25'd0, num_symbols_q} : {27'd0, num_states_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= 5'd16;
			num_symbols_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				num_symbols_q <= pwdata[6:0];
			end else begin
				num_states_q <= pwdata[4:0];
			end
		end
	end

	always_comb begin
		if (num_states_q == 5'd0) begin
			n_last = '0;
		end else if (32'(num_states_q) > MAX_STATES) begin
			n_last = SW'(MAX_STATES - 1);
		end else begin
			n_last = SW'(num_states_q - 5'd1);
		end
		if (32'(num_symbols_q) > MAX_SYMBOLS) begin
			sym_lim = 9'(MAX_SYMBOLS);
		end else begin
			sym_lim = 9'(num_symbols_q);
		end
	end

	assign sym_bad    = 9'(obs_symbol) >= sym_lim;
	assign accept     = item_valid && item_ready;
	assign obs_accept = accept && (kind == KIND_OBS);
	assign ld_pi      = accept && (kind == KIND_PI) && (32'(row_index) < MAX_STATES);
	assign ld_a       = accept && (kind == KIND_TRANS) && (32'(row_index) < MAX_STATES)
	                    && (32'(column_index) < MAX_STATES);
	assign ld_b       = accept && (kind == KIND_EMIT) && (32'(row_index) < MAX_STATES)
	                    && (32'(column_index) < MAX_SYMBOLS);

	assign a_wr_addr  = AAW'(32'(row_index) * MAX_STATES + 32'(column_index));
	assign b_wr_addr  = BAW'(32'(row_index) * MAX_SYMBOLS + 32'(column_index));
	assign a_rd_addr  = AAW'(32'(i_q) * MAX_STATES + 32'(j_q));
	assign b_rd_addr  = BAW'(32'(j_q) * MAX_SYMBOLS + 32'(sym_q));
	assign fv_rd_addr = FAW'(32'(bank_q) * MAX_STATES + 32'(i_q));
	assign fv_wr_addr = FAW'(32'(~bank_q) * MAX_STATES + 32'(j_q));
	assign fv_rd      = fv_vld_rd_q ? fv_rd_q : 64'd0;

	always_ff @(posedge clk) begin
		if (ld_pi) begin
			pi_mem[SW'(row_index)] <= table_value;
		end
		if (rd_en) begin
			pi_rd_q <= pi_mem[j_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_a) begin
			a_mem[a_wr_addr] <= table_value;
		end
		if (rd_en) begin
			a_rd_q <= a_mem[a_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_b) begin
			b_mem[b_wr_addr] <= table_value;
		end
		if (rd_en) begin
			b_rd_q <= b_mem[b_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fv_we) begin
			fv_mem[fv_wr_addr] <= fpu_rsp.result;
		end
		if (rd_en) begin
			fv_rd_q     <= fv_mem[fv_rd_addr];
			fv_vld_rd_q <= fv_vld_q[fv_rd_addr];
		end
	end

	always_comb begin
		st_d       = st_q;
		i_d        = i_q;
		j_d        = j_q;
		acc_d      = acc_q;
		bank_d     = bank_q;
		clr_vld    = 1'b0;
		fv_we      = 1'b0;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		item_ready = (st_q == S_IDLE);
		fpu_req    = '0;
		case (st_q)
			S_IDLE: begin
				if (obs_accept) begin
					st_d = sym_bad ? S_OUT : S_CLR;
				end
			end
			S_CLR: begin
				clr_vld = 1'b1;
				i_d     = '0;
				j_d     = '0;
				acc_d   = 64'd0;
				st_d    = S_RD;
			end
			S_RD: begin
				rd_en = 1'b1;
				st_d  = S_OPA;
			end
			S_OPA: begin
				fpu_req.start = 1'b1;
				if (first_q) begin
					fpu_req.a = pi_rd_q;
					fpu_req.b = b_rd_q;
					st_d      = S_WMUL;
				end else begin
					fpu_req.a = fv_rd;
					fpu_req.b = a_rd_q;
					st_d      = S_WPROD;
				end
			end
			S_WPROD: begin
				if (fpu_rsp.done) begin
					st_d = S_ADD;
				end
			end
			S_ADD: begin
				fpu_req.start  = 1'b1;
				fpu_req.op_add = 1'b1;
				fpu_req.a      = acc_q;
				fpu_req.b      = fpu_rsp.result;
				st_d           = S_WACC;
			end
			S_WACC: begin
				if (fpu_rsp.done) begin
					acc_d = fpu_rsp.result;
					if (i_q == n_last) begin
						st_d = S_EMUL;
					end else begin
						i_d  = i_q + 1'b1;
						st_d = S_RD;
					end
				end
			end
			S_EMUL: begin
				fpu_req.start = 1'b1;
				fpu_req.a     = acc_q;
				fpu_req.b     = b_rd_q;
				st_d          = S_WMUL;
			end
			S_WMUL: begin
				if (fpu_rsp.done) begin
					fv_we = 1'b1;
					if (j_q == n_last) begin
						st_d = S_SWAP;
					end else begin
						j_d   = j_q + 1'b1;
						i_d   = '0;
						acc_d = 64'd0;
						st_d  = S_RD;
					end
				end
			end
			S_SWAP: begin
				bank_d = ~bank_q;
				i_d    = '0;
				acc_d  = 64'd0;
				st_d   = S_SRD;
			end
			S_SRD: begin
				rd_en = 1'b1;
				st_d  = S_SADD;
			end
			S_SADD: begin
				fpu_req.start  = 1'b1;
				fpu_req.op_add = 1'b1;
				fpu_req.a      = acc_q;
				fpu_req.b      = fv_rd;
				st_d           = S_WSUM;
			end
			S_WSUM: begin
				if (fpu_rsp.done) begin
					acc_d = fpu_rsp.result;
					if (i_q == n_last) begin
						st_d = S_OUT;
					end else begin
						i_d  = i_q + 1'b1;
						st_d = S_SRD;
					end
				end
			end
			S_OUT: begin
				if (!result_valid_q || result_ready) begin
					out_load = 1'b1;
					st_d     = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			i_q            <= '0;
			j_q            <= '0;
			bank_q         <= 1'b0;
			fv_vld_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			i_q    <= i_d;
			j_q    <= j_d;
			bank_q <= bank_d;
			for (int k = 0; k < FVD; k++) begin
				if (clr_vld && ((k >= MAX_STATES) != bank_q)) begin
					fv_vld_q[k] <= 1'b0;
				end
			end
			if (fv_we) begin
				fv_vld_q[fv_wr_addr] <= 1'b1;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		if (obs_accept) begin
			sym_q   <= obs_symbol;
			first_q <= first_of_sequence;
			last_q  <= last_of_sequence;
			err_q   <= sym_bad;
		end
		if (out_load) begin
			prob_q <= err_q ? 64'd0 : acc_q;
			eos_q  <= err_q ? 1'b0 : last_q;
			serr_q <= err_q;
		end
	end

	assign result_valid       = result_valid_q;
	assign prefix_probability = prob_q;
	assign end_of_sequence    = eos_q;
	assign symbol_error       = serr_q;

endmodule

@@ tb/hmm_forward_probability_tb.sv @@
// Testbench for hmm_forward_probability: table loads and observation sequences
// against a double-precision forward-pass predictor, with random idling and stalls.
`timescale 1ns / 1ps

module hmm_forward_probability_tb;
	import hfp_pkg::*;

	localparam int NSTATES   = 16;
	localparam int NSYMBOLS  = 64;
	localparam int MAX_CYCLES = 40000000;
	localparam logic [2:0] ADDR_NUM_STATES  = 3'd0;
	localparam logic [2:0] ADDR_NUM_SYMBOLS = 3'd4;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  row;
		logic [5:0]  col;
		logic [63:0] val;
		logic [5:0]  sym;
		logic        first;
		logic        last;
	} hmm_item_t;

	typedef struct {
		logic [63:0] prob;
		logic        eos;
		logic        err;
	} prob_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  kind = '0;
	logic [3:0]  row_index = '0;
	logic [5:0]  column_index = '0;
	logic [63:0] table_value = '0;
	logic [5:0]  obs_symbol = '0;
	logic        first_of_sequence = 1'b0;
	logic        last_of_sequence = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [63:0] prefix_probability;
	logic        end_of_sequence;
	logic        symbol_error;

	hmm_forward_probability DUT (.*);

	always #4 clk = ~clk;

	hmm_item_t    pending_items[$];
	prob_result_t expected_probs[$];
	int           error_count = 0;
	int           idle_pct = 0;
	int           stall_pct = 0;
	int           cycle_count = 0;

	// predictor state
	logic [4:0] cfg_states = 5'd16;
	logic [6:0] cfg_symbols = 7'd64;
	real        pi_tab[NSTATES];
	real        a_tab[NSTATES][NSTATES];
	real        b_tab[NSTATES][NSYMBOLS];
	real        fwd[NSTATES];

	// stimulus bookkeeping: entries loaded so far
	bit pi_ok[NSTATES];
	bit a_ok[NSTATES][NSTATES];
	bit b_ok[NSTATES][NSYMBOLS];
	int gen_count;

	function automatic int states_used(logic [4:0] ns);
		if (ns == 0) return 1;
		if (ns > NSTATES) return NSTATES;
		return int'(ns);
	endfunction

	function automatic int symbols_used(logic [6:0] ss);
		if (ss > NSYMBOLS) return NSYMBOLS;
		return int'(ss);
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic bit is_nan(logic [63:0] b);
		return b[62:52] == EXP_MAX && b[51:0] != 0;
	endfunction

	task automatic forward_step(input hmm_item_t it);
		int n;
		real nxt[NSTATES];
		real acc;
		real total;
		prob_result_t r;
		case (it.kind)
			KIND_PI: pi_tab[it.row] = $bitstoreal(it.val);
			KIND_TRANS: if (it.col < NSTATES) a_tab[it.row][it.col] = $bitstoreal(it.val);
			KIND_EMIT: b_tab[it.row][it.col] = $bitstoreal(it.val);
			KIND_OBS: begin
				if (it.sym >= symbols_used(cfg_symbols)) begin
					r.prob = '0;
					r.eos = 1'b0;
					r.err = 1'b1;
				end else begin
					n = states_used(cfg_states);
					for (int j = 0; j < NSTATES; j++) nxt[j] = 0.0;
					for (int j = 0; j < n; j++) begin
						if (it.first) begin
							nxt[j] = pi_tab[j] * b_tab[j][it.sym];
						end else begin
							acc = 0.0;
							for (int i = 0; i < n; i++) acc = acc + fwd[i] * a_tab[i][j];
							nxt[j] = acc * b_tab[j][it.sym];
						end
					end
					total = 0.0;
					for (int j = 0; j < NSTATES; j++) fwd[j] = nxt[j];
					for (int j = 0; j < n; j++) total = total + fwd[j];
					r.prob = $realtobits(total);
					r.eos = it.last;
					r.err = 1'b0;
				end
				expected_probs.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) forward_step('{kind, row_index, column_index,
				table_value, obs_symbol, first_of_sequence, last_of_sequence});
			if (!item_valid || item_ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
					hmm_item_t it;
					it = pending_items.pop_front();
					item_valid <= 1'b1;
					kind <= it.kind;
					row_index <= it.row;
					column_index <= it.col;
					table_value <= it.val;
					obs_symbol <= it.sym;
					first_of_sequence <= it.first;
					last_of_sequence <= it.last;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_probs.size() == 0) begin
					report("unexpected result", prefix_probability, '0);
				end else begin
					prob_result_t e;
					e = expected_probs.pop_front();
					if (is_nan(e.prob) ? !is_nan(prefix_probability)
						: prefix_probability !== e.prob)
						report("prefix_probability", prefix_probability, e.prob);
					if (end_of_sequence !== e.eos)
						report("end_of_sequence", 64'(end_of_sequence), 64'(e.eos));
					if (symbol_error !== e.err)
						report("symbol_error", 64'(symbol_error), 64'(e.err));
				end
			end
			result_ready <= $urandom_range(99) >= stall_pct;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand_prob();
		if ($urandom_range(15) == 0) return {$urandom, $urandom};
		return $realtobits($urandom_range(1000000) / 1000000.0);
	endfunction

	task automatic push_item(input logic [1:0] k, input int row, input int col,
		input logic [63:0] v, input int sym, input bit first, input bit last);
		pending_items.push_back('{k, row[3:0], col[5:0], v, sym[5:0], first, last});
		if (k == KIND_PI) pi_ok[row] = 1;
		if (k == KIND_TRANS && col < NSTATES) a_ok[row][col] = 1;
		if (k == KIND_EMIT) b_ok[row][col] = 1;
		gen_count++;
	endtask

	// load whatever the observation would read that is still unwritten
	task automatic push_obs(input int sym, input bit first, input bit last);
		int n;
		n = states_used(cfg_states);
		if (sym < symbols_used(cfg_symbols)) begin
			for (int j = 0; j < n; j++) begin
				if (first && !pi_ok[j]) push_item(KIND_PI, j, 0, rand_prob(), 0, 0, 0);
				if (!first)
					for (int i = 0; i < n; i++)
						if (!a_ok[i][j]) push_item(KIND_TRANS, i, j, rand_prob(), 0, 0, 0);
				if (!b_ok[j][sym]) push_item(KIND_EMIT, j, sym, rand_prob(), 0, 0, 0);
			end
		end
		push_item(KIND_OBS, $urandom_range(15), $urandom_range(63), {$urandom, $urandom},
			sym, first, last);
	endtask

	task automatic push_sequence();
		int len;
		int s;
		int sym;
		bit first;
		bit last;
		s = symbols_used(cfg_symbols);
		len = $urandom_range(1, 6);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(2))
					0: push_item(KIND_PI, $urandom_range(15), $urandom_range(63),
						rand_prob(), $urandom_range(63), $urandom_range(1), $urandom_range(1));
					1: push_item(KIND_TRANS, $urandom_range(15), $urandom_range(63),
						rand_prob(), $urandom_range(63), $urandom_range(1), $urandom_range(1));
					default: push_item(KIND_EMIT, $urandom_range(15), $urandom_range(63),
						rand_prob(), $urandom_range(63), $urandom_range(1), $urandom_range(1));
				endcase
			end
			sym = (s == 0 || $urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(s - 1);
			first = (k == 0) ^ ($urandom_range(9) == 0);
			last = (k == len - 1) ^ ($urandom_range(9) == 0);
			push_obs(sym, first, last);
		end
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_NUM_STATES) cfg_states = data[4:0];
		if (addr == ADDR_NUM_SYMBOLS) cfg_symbols = data[6:0];
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() > 0 || item_valid || expected_probs.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(input int ns, input int ss);
		apb_write(ADDR_NUM_STATES, 32'({$urandom, 5'b0} | ns));
		apb_write(ADDR_NUM_SYMBOLS, 32'({$urandom, 7'b0} | ss));
	endtask

	initial begin
		int phase_states[8] = '{1, 0, 4, 3, 16, 31, 5, 8};
		int phase_symbols[8] = '{1, 0, 8, 64, 2, 127, 16, 33};
		int phase_items[8] = '{120, 40, 200, 200, 80, 60, 200, 200};
		for (int j = 0; j < NSTATES; j++) begin
			pi_tab[j] = 0.0;
			fwd[j] = 0.0;
			for (int i = 0; i < NSTATES; i++) a_tab[j][i] = 0.0;
			for (int i = 0; i < NSYMBOLS; i++) b_tab[j][i] = 0.0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_config(2, 4);
		push_obs(0, 0, 0);
		push_item(KIND_TRANS, 1, 40, '1, 0, 0, 0);
		push_item(KIND_PI, 0, 0, '0, 0, 0, 0);
		push_item(KIND_PI, 1, 0, 64'h3FF0_0000_0000_0000, 0, 0, 0);
		push_item(KIND_EMIT, 0, 1, 64'h3FF0_0000_0000_0000, 0, 0, 0);
		push_item(KIND_EMIT, 1, 1, 64'h8000_0000_0000_0000, 0, 0, 0);
		push_obs(1, 1, 0);
		push_obs(2, 0, 1);
		push_item(KIND_EMIT, 0, 3, '1, 0, 0, 0);
		push_obs(3, 1, 1);
		push_obs(4, 1, 0);
		push_obs(63, 0, 1);
		push_item(KIND_EMIT, 15, 63, 64'h7FEF_FFFF_FFFF_FFFF, 0, 0, 0);
		push_item(KIND_EMIT, 0, 3, 64'h0000_0000_0000_0001, 0, 0, 0);
		push_obs(3, 1, 0);
		push_obs(3, 0, 1);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_config(phase_states[p], phase_symbols[p]);
			idle_pct = (p % 4 == 1) ? 46 : (p % 4 == 3) ? 24 : 0;
			stall_pct = (p % 4 == 2) ? 46 : (p % 4 == 3) ? 24 : 0;
			gen_count = 0;
			while (gen_count < phase_items[p]) push_sequence();
			drain();
		end

		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
